>>> hw/rtl/cvt_pkg.sv
`timescale 1ns / 1ps

package cvt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_DROP = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [30:0]        table_key;
    logic signed [63:0] new_value;
  } req_t;

  typedef struct packed {
    logic               status;
    logic signed [63:0] value_out;
    logic               hit;
  } rsp_t;

  // one table slot as held in the RAM
  typedef struct packed {
    logic [30:0] key;
    logic [63:0] value;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

>>> hw/rtl/cvt_ram.sv
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read per cycle
module cvt_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 95,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/cvt_engine.sv
`timescale 1ns / 1ps

// Scan / update sequencer. Slots 0..count-1 are live and packed;
// slots at or above count are never read.
module cvt_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cvt_pkg::req_t     req,
  output logic              res_valid,
  input  logic              res_ready,
  output cvt_pkg::rsp_t     res_word,
  output cvt_pkg::mem_req_t mem_req,
  input  cvt_pkg::entry_t   rd_data
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_LAST_RD = 5'b00100,
    S_LAST_WT = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  localparam logic [cvt_pkg::CNT_W-1:0] ENTRIES_C = cvt_pkg::CNT_W'(cvt_pkg::ENTRIES);
  localparam logic [cvt_pkg::CNT_W-1:0] ONE_C     = cvt_pkg::CNT_W'(1);

  state_t                      state;
  logic [1:0]                  op;
  logic [30:0]                 key;
  logic [63:0]                 val;
  logic [cvt_pkg::CNT_W-1:0]   idx;        // next slot to read
  logic                        cmp_valid;  // read in flight last cycle
  logic [cvt_pkg::IDX_W-1:0]   cmp_idx;    // slot of that read
  logic [cvt_pkg::IDX_W-1:0]   found_idx;
  logic [cvt_pkg::CNT_W-1:0]   count;
  cvt_pkg::rsp_t               res;

  logic                        match;
  logic                        more;
  logic                        room;
  logic [cvt_pkg::CNT_W-1:0]   cnt_dec;
  logic [cvt_pkg::IDX_W-1:0]   last_idx;

  assign match    = cmp_valid && (rd_data.key == key);
  assign more     = idx < count;
  assign room     = count < ENTRIES_C;
  assign cnt_dec  = count - ONE_C;
  assign last_idx = cnt_dec[cvt_pkg::IDX_W-1:0];

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_word  = res;

  always_comb begin
    mem_req = '0;
    case (state)
      S_SCAN: begin
        if (match) begin
          if (op == cvt_pkg::OP_SET) begin
            mem_req.wr_en         = 1'b1;
            mem_req.wr_addr       = cmp_idx;
            mem_req.wr_data.key   = key;
            mem_req.wr_data.value = val;
          end
        end else if (more) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx[cvt_pkg::IDX_W-1:0];
        end else if (op == cvt_pkg::OP_SET && room) begin
          // append at the first free slot
          mem_req.wr_en         = 1'b1;
          mem_req.wr_addr       = count[cvt_pkg::IDX_W-1:0];
          mem_req.wr_data.key   = key;
          mem_req.wr_data.value = val;
        end
      end
      S_LAST_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = last_idx;
      end
      S_LAST_WT: begin
        // last entry fills the hole left by the drop
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = found_idx;
        mem_req.wr_data = rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op        <= req.operation;
            key       <= req.table_key;
            val       <= req.new_value;
            idx       <= '0;
            cmp_valid <= 1'b0;
            res       <= '0;
            // key zero and the spare opcode touch nothing
            if (req.table_key != 31'd0 &&
                (req.operation == cvt_pkg::OP_SET || req.operation == cvt_pkg::OP_GET ||
                 req.operation == cvt_pkg::OP_DROP)) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            cmp_valid <= 1'b0;
            found_idx <= cmp_idx;
            case (op)
              cvt_pkg::OP_GET: begin
                res.value_out <= rd_data.value;
                res.hit       <= 1'b1;
                state         <= S_DONE;
              end
              cvt_pkg::OP_DROP: begin
                if (cmp_idx == last_idx) begin
                  count   <= cnt_dec;
                  res.hit <= 1'b1;
                  state   <= S_DONE;
                end else begin
                  state <= S_LAST_RD;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end else if (more) begin
            cmp_valid <= 1'b1;
            cmp_idx   <= idx[cvt_pkg::IDX_W-1:0];
            idx       <= idx + ONE_C;
          end else begin
            cmp_valid <= 1'b0;
            if (op == cvt_pkg::OP_SET) begin
              if (room) begin
                count <= count + ONE_C;
              end else begin
                res.status <= 1'b1;
              end
            end
            state <= S_DONE;
          end
        end
        S_LAST_RD: begin
          state <= S_LAST_WT;
        end
        S_LAST_WT: begin
          count   <= cnt_dec;
          res.hit <= 1'b1;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ENTRIES_C)
    else $error("entry count above table size");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (state == S_SCAN || state == S_LAST_WT))
    else $error("RAM write outside scan or move");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |=> $stable(count))
    else $error("count moved with no operation in progress");

  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_word.hit && res_word.status))
    else $error("hit and full flagged together");
`endif

endmodule

>>> hw/rtl/cached_value_table.sv
`timescale 1ns / 1ps

// Channel  Handshake              Word
// -------  ---------------------  --------------------------------------
// req      req_valid / req_ready  cvt_pkg::req_t {operation, key, value}
// rsp      rsp_valid / rsp_ready  cvt_pkg::rsp_t {status, value_out, hit}
//
// One request in the engine at a time. A set, get or drop with a nonzero key scans
// the live slots through the registered RAM read port; a drop that moves the last
// entry adds a read and a write back. Key zero and the spare opcode skip the scan.
// Reset only zeroes the entry count; slots past it are never read, so no clearing pass.
// The response register frees the engine: the next request is taken while one waits.
module cached_value_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cvt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cvt_pkg::rsp_t rsp
);

  cvt_pkg::mem_req_t mem_req;
  cvt_pkg::entry_t   rd_data;
  cvt_pkg::rsp_t     res_word;
  logic              res_valid;
  logic              res_ready;

  // packed key/value slots
  cvt_ram #(
    .DEPTH (cvt_pkg::ENTRIES),
    .WIDTH ($bits(cvt_pkg::entry_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  // scan, update and compaction sequencer
  cvt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  // response register: load when empty or being drained
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res_word;
    end
  end

endmodule

>>> bench/cached_value_table_test.sv
`timescale 1ns / 1ps

module cached_value_table_test;
  import cvt_pkg::*;

  // opcode three has no name in the package; the block must treat it as a no-op
  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam logic [30:0] KEY_MAX     = 31'h7FFF_FFFF;
  localparam logic [63:0] VAL_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int KEY_POOL       = 96;    // more keys than slots so sets can hit full
  localparam int ITEMS_PER_MIX  = 175;   // four idling phases, ~700 words in all
  localparam int STALL_LIMIT    = 3000;  // cycles with no handshake on either side
  localparam int PRESSURE_HOLD  = 400;   // receiver hold-off that backs up the block
  localparam int DRAIN_CYCLES   = 100;   // extra wait once every expected response is in

  typedef enum { MIX_FILL, MIX_DRAIN, MIX_EVEN } traffic_mix_t;

  typedef struct packed {
    req_t w;
    logic typed;   // 1: want holds a hand-written result
    rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // shadow copy of the table, kept in step with accepted request words
  logic [30:0] mirror_key [ENTRIES];
  logic [63:0] mirror_val [ENTRIES];
  int          mirror_count;

  logic [30:0] key_pool [KEY_POOL];
  int          fill_cursor;

  rsp_t        expected_rsp [$];
  plan_row_t   directed_rows [$];
  int          mismatches;

  // idling knobs, written by the stimulus thread, read by both sides
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_req;

  always #5 clk = ~clk;

  cached_value_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Live entries sit in slots 0 .. count-1, so lookups only scan those.
  function automatic int find_live(input logic [30:0] k);
    int i;
    int found;
    found = -1;
    if (k != '0)
      for (i = 0; i < mirror_count && found < 0; i++)
        if (mirror_key[i] == k) found = i;
    return found;
  endfunction

  // Applies one request word to the shadow table and returns its response.
  function automatic rsp_t apply_to_table(input req_t w);
    rsp_t r;
    int   i;
    int   slot;
    int   last;
    r = '0;
    slot = -1;
    case (w.operation)
      OP_SET: begin
        // key zero is a no-op; otherwise first slot that matches or is empty
        if (w.table_key != '0) begin
          for (i = 0; i < ENTRIES && slot < 0; i++)
            if (mirror_key[i] == w.table_key || mirror_key[i] == '0) slot = i;
          if (slot < 0) begin
            r.status = 1'b1;
          end else begin
            if (mirror_key[slot] == '0 && mirror_count < ENTRIES) mirror_count++;
            mirror_key[slot] = w.table_key;
            mirror_val[slot] = w.new_value;
          end
        end
      end
      OP_GET: begin
        slot = find_live(w.table_key);
        if (slot >= 0) begin
          r.value_out = mirror_val[slot];
          r.hit = 1'b1;
        end
      end
      OP_DROP: begin
        // last live entry moves into the hole; dropping the last one just clears it
        slot = find_live(w.table_key);
        if (slot >= 0 && mirror_count > 0) begin
          last = mirror_count - 1;
          mirror_key[slot] = mirror_key[last];
          mirror_val[slot] = mirror_val[last];
          mirror_key[last] = '0;
          mirror_val[last] = '0;
          mirror_count--;
          r.hit = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [30:0] k,
                                  input logic [63:0] v, input logic typed,
                                  input logic st, input logic [63:0] vo, input logic h);
    plan_row_t row;
    row.w.operation = op;
    row.w.table_key = k;
    row.w.new_value = v;
    row.typed = typed;
    row.want.status = st;
    row.want.value_out = vo;
    row.want.hit = h;
    directed_rows.push_back(row);
  endfunction

  // Random request word. Gets and drops mostly aim at live keys so that the
  // move-on-drop path gets real work; sets walk the key pool to fill the table.
  function automatic req_t next_random_word(input traffic_mix_t mix);
    req_t w;
    int   roll;
    int   set_pct;
    int   get_pct;
    case (mix)
      MIX_FILL:  begin set_pct = 88; get_pct = 8;  end
      MIX_DRAIN: begin set_pct = 15; get_pct = 25; end
      default:   begin set_pct = 40; get_pct = 35; end
    endcase
    case ($urandom_range(0, 9))
      0:       w.new_value = VAL_MAX_POS;
      1:       w.new_value = VAL_MIN_NEG;
      default: w.new_value = {$urandom, $urandom};
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      // noise: any opcode including the spare one, key zero or a stray key
      w.operation = 2'($urandom_range(0, 3));
      w.table_key = (roll < 2) ? 31'd0 : 31'($urandom);
    end else if (roll < 4 + set_pct) begin
      w.operation = OP_SET;
      if ($urandom_range(0, 99) < 60) begin
        w.table_key = key_pool[fill_cursor];
        fill_cursor = (fill_cursor + 1) % KEY_POOL;
      end else begin
        w.table_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      end
    end else begin
      w.operation = (roll < 4 + set_pct + get_pct) ? OP_GET : OP_DROP;
      if (mirror_count > 0 && $urandom_range(0, 99) < 75)
        w.table_key = mirror_key[$urandom_range(0, mirror_count - 1)];
      else
        w.table_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end
    return w;
  endfunction

  // Offers one word, holds it until taken, then books its expected response.
  // valid is only dropped when an idle gap actually follows.
  task automatic send_word(input req_t w, input logic typed, input rsp_t want);
    rsp_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!req_ready);
    predicted = apply_to_table(w);
    expected_rsp.push_back(typed ? want : predicted);
  endtask

  // Response side: checks each accepted word, then picks the next ready.
  initial begin : response_side
    rsp_t want;
    int   hold_left;
    bit   hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected word", rsp.value_out, '0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.value_out !== want.value_out)
            report_mismatch("value_out", rsp.value_out, want.value_out);
          if (rsp.hit !== want.hit)
            report_mismatch("hit", rsp.hit, want.hit);
        end
      end
      if (hold_req > 0 && !hold_taken) begin
        hold_left = hold_req;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck = 0;
      else stuck++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int           i;
    int           phase;
    int           useful;
    int           seg_left;
    traffic_mix_t mix;
    req_t         w;
    int           idle_send [4];
    int           idle_recv [4];

    mismatches = 0;
    mirror_count = 0;
    fill_cursor = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    for (i = 0; i < ENTRIES; i++) begin
      mirror_key[i] = '0;
      mirror_val[i] = '0;
    end
    key_pool[0] = KEY_MAX;
    key_pool[1] = 31'd1;
    for (i = 2; i < KEY_POOL; i++) begin
      key_pool[i] = 31'($urandom);
      if (key_pool[i] == '0) key_pool[i] = 31'd2;
    end

    // Directed words. Typed results are the obvious ones; the rest come from
    // the shadow table. Columns: op, key, value, typed, status, value_out, hit.
    add_row(OP_GET,   31'd5,         64'd0,        1, 0, 64'd0,       0); // empty after reset
    add_row(OP_DROP,  31'd5,         64'd0,        1, 0, 64'd0,       0);
    add_row(OP_SET,   31'd0,         64'h123,      1, 0, 64'd0,       0); // key zero ignored
    add_row(OP_SPARE, 31'd7,         VAL_ONES,     1, 0, 64'd0,       0);
    add_row(OP_SET,   KEY_MAX,       VAL_MAX_POS,  1, 0, 64'd0,       0);
    add_row(OP_GET,   KEY_MAX,       64'd0,        1, 0, VAL_MAX_POS, 1);
    add_row(OP_SET,   31'd1,         VAL_MIN_NEG,  1, 0, 64'd0,       0);
    add_row(OP_GET,   31'd1,         64'd0,        1, 0, VAL_MIN_NEG, 1);
    add_row(OP_SET,   31'd1,         VAL_ONES,     1, 0, 64'd0,       0); // overwrite
    add_row(OP_GET,   31'd1,         64'd0,        1, 0, VAL_ONES,    1);
    add_row(OP_GET,   31'd0,         64'd0,        1, 0, 64'd0,       0); // key zero misses
    add_row(OP_DROP,  31'd0,         64'd0,        1, 0, 64'd0,       0);
    add_row(OP_DROP,  31'd3,         64'd0,        1, 0, 64'd0,       0); // absent key
    add_row(OP_SET,   31'd2,         64'h5555_5555_5555_5555, 0, 0, 64'd0, 0);
    add_row(OP_DROP,  KEY_MAX,       64'd0,        1, 0, 64'd0,       1); // moves key 2 down
    add_row(OP_GET,   31'd2,         64'd0,        0, 0, 64'd0,       0);
    add_row(OP_GET,   KEY_MAX,       64'd0,        1, 0, 64'd0,       0);
    add_row(OP_DROP,  31'd1,         64'd0,        1, 0, 64'd0,       1); // last live entry
    add_row(OP_GET,   31'd1,         64'd0,        1, 0, 64'd0,       0);
    add_row(OP_SET,   31'h2AAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 64'd0, 0);
    add_row(OP_GET,   31'h2AAA_AAAA, 64'd0,        0, 0, 64'd0,       0);
    add_row(OP_SPARE, 31'd2,         VAL_ONES,     1, 0, 64'd0,       0); // spare leaves table
    add_row(OP_GET,   31'd2,         64'd0,        0, 0, 64'd0,       0);
    add_row(OP_DROP,  31'd2,         64'd0,        1, 0, 64'd0,       1);
    add_row(OP_DROP,  31'h2AAA_AAAA, 64'd0,        1, 0, 64'd0,       1);

    // idling per phase: none, sender gaps, receiver stalls, both
    idle_send = '{0, 85, 0, 37};
    idle_recv = '{0, 0, 85, 37};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

    // Random traffic in segments of fill-, drain- or even-biased words. The
    // first segment fills past capacity so full shows up early; the receiver
    // also holds off for a long stretch so the block backs up its input.
    seg_left = 140;
    mix = MIX_FILL;
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_send[phase];
      recv_stall_pct = idle_recv[phase];
      if (phase == 0) hold_req = PRESSURE_HOLD;
      useful = 0;
      while (useful < ITEMS_PER_MIX) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 70);
          case ($urandom_range(0, 2))
            0:       mix = MIX_FILL;
            1:       mix = MIX_DRAIN;
            default: mix = MIX_EVEN;
          endcase
        end
        w = next_random_word(mix);
        send_word(w, 1'b0, '0);
        seg_left--;
        if (w.operation != OP_SPARE && w.table_key != '0) useful++;
      end
    end
    req_valid <= 1'b0;

    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cvt_pkg.sv
hw/rtl/cvt_ram.sv
hw/rtl/cvt_engine.sv
hw/rtl/cached_value_table.sv
bench/cached_value_table_test.sv
